/* rtl/sse_style_256bit_block_hash_assert.svh */
// Assertion helpers used by the hash RTL; they sample on clk and hold off while rst_n is low.
`ifndef SSE_STYLE_256BIT_BLOCK_HASH_ASSERT_SVH
`define SSE_STYLE_256BIT_BLOCK_HASH_ASSERT_SVH

// Same-cycle implication.
`define SBH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBH_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbh_pkg.sv */
package sbh_pkg;

  // Multiplier constants, one per state word
  localparam logic [31:0] K0 = 32'h98b365a1;
  localparam logic [31:0] K1 = 32'h52c69cab;
  localparam logic [31:0] K2 = 32'hb76a9a41;
  localparam logic [31:0] K3 = 32'hcc4d2c7b;

  // Random seed words for the initial state
  localparam logic [63:0] RND0 = 64'hc7265595564a4447;
  localparam logic [63:0] RND1 = 64'h128fa608e20c241d;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEED       = 2'd0;
  localparam logic [1:0] CFG_MIX_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BYTE_SWAP  = 2'd2;

  // Post-add mixing applied by the shared adder
  typedef logic [1:0] post_t;
  localparam post_t POST_NONE = 2'd0;
  localparam post_t POST_X29  = 2'd1;
  localparam post_t POST_X21  = 2'd2;

  typedef struct packed {
    logic  sub;
    post_t post;
  } alu_ctl_t;

endpackage

/* rtl/sse_style_256bit_block_hash.sv */
// 256-bit block hash over a message fed as 16-byte beats. Each beat is masked to its valid byte
// count, optionally byte-reversed, and folded into a four-word state by a single registered
// 32x32 multiplier and a single 64-bit add/subtract unit, one state word update per cycle after
// the multiply step of a 23-step sequencer. A block with data is taken in the idle state, then
// runs the 23 steps; the last block adds a setup state, a second 23-step round and a done state
// that loads the digest; an empty last beat goes straight to setup. in_stall is high until idle.
// The digest beat sits in an output register; the next message may start while it waits, but
// its own digest waits for the previous one to be taken. cfg_ready is always high; writing the
// seed restarts the message.
`include "sse_style_256bit_block_hash_assert.svh"

module sse_style_256bit_block_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_word0,
  output logic [63:0] out_hash_word1,
  output logic [63:0] out_hash_word2,
  output logic [63:0] out_hash_word3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  localparam logic [4:0] STEP_MUL       = 5'd0;
  localparam logic [4:0] STEP_SUB_FIRST = 5'd1;
  localparam logic [4:0] STEP_SUB_LAST  = 5'd4;
  localparam logic [4:0] STEP_ADD_FIRST = 5'd5;
  localparam logic [4:0] STEP_ADD_LAST  = 5'd8;
  localparam logic [4:0] STEP_FOLD1     = 5'd9;
  localparam logic [4:0] STEP_FOLD0     = 5'd10;
  localparam logic [4:0] STEP_FOLD3     = 5'd11;
  localparam logic [4:0] STEP_FOLD2     = 5'd12;
  localparam logic [4:0] STEP_DIFF0     = 5'd13;
  localparam logic [4:0] STEP_DIFF1     = 5'd14;
  localparam logic [4:0] STEP_SH1A      = 5'd15;
  localparam logic [4:0] STEP_SH1B      = 5'd16;
  localparam logic [4:0] STEP_SH2A      = 5'd17;
  localparam logic [4:0] STEP_SH2B      = 5'd18;
  localparam logic [4:0] STEP_SH3A      = 5'd19;
  localparam logic [4:0] STEP_SH3B      = 5'd20;
  localparam logic [4:0] STEP_SH4A      = 5'd21;
  localparam logic [4:0] STEP_SH4B      = 5'd22;

  localparam logic [4:0] MAX_BYTES = 5'd16;

  function automatic logic [63:0] rev64(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = v[8*(7-b) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] sel_word(input logic [1:0] idx, input logic [63:0] w0,
                                           input logic [63:0] w1, input logic [63:0] w2,
                                           input logic [63:0] w3);
    logic [63:0] r;
    unique case (idx)
      2'd0:    r = w0;
      2'd1:    r = w1;
      2'd2:    r = w2;
      default: r = w3;
    endcase
    return r;
  endfunction

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        fin_r, fin_nxt;
  logic        last_r, last_nxt;
  logic [63:0] w0_r, w0_nxt, w1_r, w1_nxt;
  logic [63:0] s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic        mix_length_r, mix_length_nxt;
  logic        byte_swap_r, byte_swap_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hw0_r, hw0_nxt, hw1_r, hw1_nxt, hw2_r, hw2_nxt, hw3_r, hw3_nxt;

  logic [4:0]         nv;
  logic [63:0]        mask_lo, mask_hi, blk_lo, blk_hi, len2;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        product;
  logic [63:0]        op_a, op_b, alu_res, dst_old;
  logic [1:0]         dst;
  logic               wr_en, save_tmp;
  sbh_pkg::alu_ctl_t  ctl;

  // Clamp the count, clear bytes past it, optionally byte-reverse, and form the length word
  always_comb begin
    nv = (in_valid_bytes > MAX_BYTES) ? MAX_BYTES : in_valid_bytes;
    for (int k = 0; k < 8; k++) begin
      mask_lo[8*k +: 8] = {8{5'(k) < nv}};
      mask_hi[8*k +: 8] = {8{5'(k + 8) < nv}};
    end
    blk_lo = byte_swap_r ? rev64(in_block_lo & mask_lo) : (in_block_lo & mask_lo);
    blk_hi = byte_swap_r ? rev64(in_block_hi & mask_hi) : (in_block_hi & mask_hi);
    len2   = mix_length_r ? {byte_count_r, byte_count_r} : 64'd0;
  end

  // Pick multiplier operands for the word being loaded
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    begin mul_a = sbh_pkg::K0; mul_b = w1_r[31:0];  end
      2'd1:    begin mul_a = sbh_pkg::K1; mul_b = w1_r[63:32]; end
      2'd2:    begin mul_a = sbh_pkg::K2; mul_b = w0_r[31:0];  end
      default: begin mul_a = sbh_pkg::K3; mul_b = w0_r[63:32]; end
    endcase
  end

  sbh_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .product (product)
  );

  // Decode the step into one state word update
  always_comb begin
    dst      = 2'd0;
    op_a     = s0_r;
    op_b     = 64'd0;
    ctl.sub  = 1'b0;
    ctl.post = sbh_pkg::POST_NONE;
    wr_en    = 1'b1;
    save_tmp = 1'b0;
    unique case (step_r) inside
      [STEP_SUB_FIRST:STEP_SUB_LAST]: begin
        dst      = step_r[1:0] - 2'd1;
        op_a     = sel_word(dst, s0_r, s1_r, s2_r, s3_r);
        op_b     = product;
        ctl.sub  = 1'b1;
        ctl.post = sbh_pkg::POST_X29;
      end
      [STEP_ADD_FIRST:STEP_ADD_LAST]: begin
        dst      = step_r[1:0] - 2'd1;
        op_a     = sel_word(dst, s0_r, s1_r, s2_r, s3_r);
        op_b     = op_a << 16;
        ctl.post = sbh_pkg::POST_X21;
      end
      STEP_FOLD1: begin
        dst  = 2'd1;
        op_a = s1_r;
        op_b = {s1_r[31:0], s0_r[63:32]};
      end
      STEP_FOLD0: begin
        op_b = {s0_r[31:0], 32'd0};
      end
      STEP_FOLD3: begin
        dst  = 2'd3;
        op_a = s3_r;
        op_b = {s3_r[31:0], s2_r[63:32]};
      end
      STEP_FOLD2: begin
        dst  = 2'd2;
        op_a = s2_r;
        op_b = {s2_r[31:0], 32'd0};
      end
      STEP_DIFF0: begin
        op_b    = s2_r;
        ctl.sub = 1'b1;
      end
      STEP_DIFF1: begin
        dst     = 2'd1;
        op_a    = s1_r;
        op_b    = s3_r;
        ctl.sub = 1'b1;
      end
      STEP_SH1A: begin
        dst      = 2'd2;
        save_tmp = 1'b1;
        op_a     = {s3_r[31:0], s2_r[63:32]};
        op_b     = s0_r;
        ctl.sub  = 1'b1;
      end
      STEP_SH1B: begin
        dst     = 2'd3;
        op_a    = {tmp_r[31:0], s3_r[63:32]};
        op_b    = s1_r;
        ctl.sub = 1'b1;
      end
      STEP_SH2A: begin
        dst      = 2'd1;
        save_tmp = 1'b1;
        op_a     = {s0_r[31:0], s0_r[63:32]};
        op_b     = s3_r;
        ctl.sub  = 1'b1;
      end
      STEP_SH2B: begin
        op_a    = tmp_r;
        op_b    = s2_r;
        ctl.sub = 1'b1;
      end
      STEP_SH3A: begin
        dst      = 2'd2;
        save_tmp = 1'b1;
        op_a     = {s2_r[31:0], s3_r[63:32]};
        op_b     = s0_r;
        ctl.sub  = 1'b1;
      end
      STEP_SH3B: begin
        dst     = 2'd3;
        op_a    = {s3_r[31:0], tmp_r[63:32]};
        op_b    = s1_r;
        ctl.sub = 1'b1;
      end
      STEP_SH4A: begin
        save_tmp = 1'b1;
        op_a     = {s0_r[31:0], s1_r[63:32]};
        op_b     = s2_r;
        ctl.sub  = 1'b1;
      end
      STEP_SH4B: begin
        dst     = 2'd1;
        op_a    = {s1_r[31:0], tmp_r[63:32]};
        op_b    = s3_r;
        ctl.sub = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    dst_old = sel_word(dst, s0_r, s1_r, s2_r, s3_r);
  end

  sbh_alu u_alu (
    .op_a   (op_a),
    .op_b   (op_b),
    .ctl    (ctl),
    .result (alu_res)
  );

  // Sequence blocks, finalization and the digest beat
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    fin_nxt        = fin_r;
    last_nxt       = last_r;
    w0_nxt         = w0_r;
    w1_nxt         = w1_r;
    s0_nxt         = s0_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    s3_nxt         = s3_r;
    tmp_nxt        = tmp_r;
    byte_count_nxt = byte_count_r;
    seed_nxt       = seed_r;
    mix_length_nxt = mix_length_r;
    byte_swap_nxt  = byte_swap_r;
    out_valid_nxt  = out_valid_r & out_stall;
    hw0_nxt        = hw0_r;
    hw1_nxt        = hw1_r;
    hw2_nxt        = hw2_r;
    hw3_nxt        = hw3_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          w0_nxt         = blk_lo;
          w1_nxt         = blk_hi;
          last_nxt       = in_last_block;
          byte_count_nxt = byte_count_r + {27'd0, nv};
          fin_nxt        = 1'b0;
          step_nxt       = STEP_MUL;
          if (nv != 5'd0) begin
            state_nxt = ST_RUN;
          end else if (in_last_block) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (wr_en) begin
          unique case (dst)
            2'd0:    s0_nxt = alu_res;
            2'd1:    s1_nxt = alu_res;
            2'd2:    s2_nxt = alu_res;
            default: s3_nxt = alu_res;
          endcase
        end
        if (save_tmp) begin
          tmp_nxt = dst_old;
        end
        step_nxt = step_r + 5'd1;
        if (step_r == STEP_SH4B) begin
          step_nxt = STEP_MUL;
          if (fin_r) begin
            state_nxt = ST_DONE;
          end else if (last_r) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        // Words 0 and 1, XORed with the length when enabled, become the final block; reload them from RND0 and RND1
        w0_nxt    = s0_r ^ len2;
        w1_nxt    = s1_r ^ len2;
        s0_nxt    = sbh_pkg::RND0;
        s1_nxt    = sbh_pkg::RND1;
        fin_nxt   = 1'b1;
        step_nxt  = STEP_MUL;
        state_nxt = ST_RUN;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          hw0_nxt        = byte_swap_r ? rev64(s0_r) : s0_r;
          hw1_nxt        = byte_swap_r ? rev64(s1_r) : s1_r;
          hw2_nxt        = byte_swap_r ? rev64(s2_r) : s2_r;
          hw3_nxt        = byte_swap_r ? rev64(s3_r) : s3_r;
          out_valid_nxt  = 1'b1;
          s0_nxt         = sbh_pkg::RND0 ^ seed_r;
          s1_nxt         = sbh_pkg::RND1 ^ seed_r;
          s2_nxt         = sbh_pkg::RND0 ^ seed_r;
          s3_nxt         = sbh_pkg::RND1 ^ seed_r;
          byte_count_nxt = 32'd0;
          fin_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; a seed write restarts the message
    if (cfg_valid) begin
      unique case (cfg_index)
        sbh_pkg::CFG_SEED: begin
          seed_nxt       = cfg_data;
          s0_nxt         = sbh_pkg::RND0 ^ cfg_data;
          s1_nxt         = sbh_pkg::RND1 ^ cfg_data;
          s2_nxt         = sbh_pkg::RND0 ^ cfg_data;
          s3_nxt         = sbh_pkg::RND1 ^ cfg_data;
          byte_count_nxt = 32'd0;
        end
        sbh_pkg::CFG_MIX_LENGTH: mix_length_nxt = cfg_data[0];
        sbh_pkg::CFG_BYTE_SWAP:  byte_swap_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_MUL;
      fin_r        <= 1'b0;
      last_r       <= 1'b0;
      s0_r         <= sbh_pkg::RND0;
      s1_r         <= sbh_pkg::RND1;
      s2_r         <= sbh_pkg::RND0;
      s3_r         <= sbh_pkg::RND1;
      byte_count_r <= 32'd0;
      seed_r       <= 64'd0;
      mix_length_r <= 1'b0;
      byte_swap_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      fin_r        <= fin_nxt;
      last_r       <= last_nxt;
      s0_r         <= s0_nxt;
      s1_r         <= s1_nxt;
      s2_r         <= s2_nxt;
      s3_r         <= s3_nxt;
      byte_count_r <= byte_count_nxt;
      seed_r       <= seed_nxt;
      mix_length_r <= mix_length_nxt;
      byte_swap_r  <= byte_swap_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w0_r  <= w0_nxt;
    w1_r  <= w1_nxt;
    tmp_r <= tmp_nxt;
    hw0_r <= hw0_nxt;
    hw1_r <= hw1_nxt;
    hw2_r <= hw2_nxt;
    hw3_r <= hw3_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_hash_word0 = hw0_r;
  assign out_hash_word1 = hw1_r;
  assign out_hash_word2 = hw2_r;
  assign out_hash_word3 = hw3_r;

  `SBH_ASSERT_NXT(a_block_starts_round, (state_r == ST_IDLE && in_valid && nv != 5'd0), (state_r == ST_RUN && step_r == STEP_MUL && !fin_r), "block with data did not start a round")
  `SBH_ASSERT_IMP(a_step_in_range, (state_r == ST_RUN), (step_r <= STEP_SH4B), "sequencer step out of range")
  `SBH_ASSERT_IMP(a_digest_from_done, $rose(out_valid_r), ($past(state_r) == ST_DONE), "digest beat raised outside the done state")
  `SBH_ASSERT_NXT(a_rearm_after_digest, (state_r == ST_DONE && !(out_valid_r && out_stall)), (state_r == ST_IDLE && byte_count_r == 32'd0 && out_valid_r), "state not rearmed after digest load")

endmodule

/* rtl/sbh_alu.sv */
module sbh_alu (
  input  logic [63:0]       op_a,
  input  logic [63:0]       op_b,
  input  sbh_pkg::alu_ctl_t ctl,
  output logic [63:0]       result
);

  logic [63:0] sum;

  // Add or subtract, then optionally fold the high bits down
  always_comb begin
    sum = ctl.sub ? (op_a - op_b) : (op_a + op_b);
    unique case (ctl.post)
      sbh_pkg::POST_X29: result = sum ^ (sum >> 29);
      sbh_pkg::POST_X21: result = sum ^ (sum >> 21);
      default:           result = sum;
    endcase
  end

endmodule

/* rtl/sbh_mul.sv */
module sbh_mul (
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [63:0] product
);

  // Register the full 64-bit product
  always_ff @(posedge clk) begin
    product <= {32'd0, mul_a} * {32'd0, mul_b};
  end

endmodule

/* verif/testbench.sv */
module testbench;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_SEED       = sbh_pkg::CFG_SEED;
  localparam logic [1:0] REG_MIX_LENGTH = sbh_pkg::CFG_MIX_LENGTH;
  localparam logic [1:0] REG_BYTE_SWAP  = sbh_pkg::CFG_BYTE_SWAP;
  localparam logic [1:0] REG_UNUSED     = 2'd3;

  // Leave margin for a last block to finish before touching registers
  localparam int DRAIN_CYCLES = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BLOCKS = 282;

  typedef logic [3:0][63:0] lanes_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  nbytes;
    logic        last;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_lo = '0;
  logic [63:0] in_block_hi = '0;
  logic [4:0]  in_valid_bytes = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_word0;
  logic [63:0] out_hash_word1;
  logic [63:0] out_hash_word2;
  logic [63:0] out_hash_word3;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Predictor copy of the block state and registers
  lanes_t      hash_state;
  logic [31:0] msg_len;
  logic [63:0] seed_q;
  logic        mix_len_q;
  logic        swap_q;

  lanes_t digests[$];
  int     errors = 0;
  int     quiet = 0;
  int     send_idle = 0;
  int     stall_pct = 0;
  lanes_t got_digest;
  lanes_t want_digest;

  sse_style_256bit_block_hash dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_lo    (in_block_lo),
    .in_block_hi    (in_block_hi),
    .in_valid_bytes (in_valid_bytes),
    .in_last_block  (in_last_block),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_word0 (out_hash_word0),
    .out_hash_word1 (out_hash_word1),
    .out_hash_word2 (out_hash_word2),
    .out_hash_word3 (out_hash_word3),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] flip_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) r[8*b +: 8] = v[8*(7-b) +: 8];
    return r;
  endfunction

  function automatic logic [63:0] byte_mask(input int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // One multiply / shift-xor / shuffle-subtract round over the four lanes
  function automatic lanes_t churn(input lanes_t s, input logic [63:0] w0, input logic [63:0] w1);
    logic [63:0] t;
    s[0] -= 64'(sbh_pkg::K0) * 64'(w1[31:0]);
    s[1] -= 64'(sbh_pkg::K1) * 64'(w1[63:32]);
    s[2] -= 64'(sbh_pkg::K2) * 64'(w0[31:0]);
    s[3] -= 64'(sbh_pkg::K3) * 64'(w0[63:32]);
    for (int i = 0; i < 4; i++) begin
      s[i] ^= s[i] >> 29;
      s[i] += s[i] << 16;
      s[i] ^= s[i] >> 21;
    end
    s[1] += (s[1] << 32) + (s[0] >> 32);
    s[0] += s[0] << 32;
    s[3] += (s[3] << 32) + (s[2] >> 32);
    s[2] += s[2] << 32;
    s[0] -= s[2];
    s[1] -= s[3];
    t = s[2];
    s[2] = ((s[2] >> 32) + (s[3] << 32)) - s[0];
    s[3] = ((s[3] >> 32) + (t << 32)) - s[1];
    t = s[1];
    s[1] = ((s[0] >> 32) + (s[0] << 32)) - s[3];
    s[0] = t - s[2];
    t = s[2];
    s[2] = ((s[3] >> 32) + (s[2] << 32)) - s[0];
    s[3] = ((t >> 32) + (s[3] << 32)) - s[1];
    t = s[0];
    s[0] = ((s[1] >> 32) + (s[0] << 32)) - s[2];
    s[1] = ((t >> 32) + (s[1] << 32)) - s[3];
    return s;
  endfunction

  task automatic rearm_state();
    hash_state[0] = sbh_pkg::RND0 ^ seed_q;
    hash_state[1] = sbh_pkg::RND1 ^ seed_q;
    hash_state[2] = hash_state[0];
    hash_state[3] = hash_state[1];
    msg_len = '0;
  endtask

  // Fold one accepted beat into the predicted state; queue a digest on a last block
  task automatic predict_digest(input block_t blk);
    int          n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len2;
    lanes_t      fin;
    n = (blk.nbytes > 5'd16) ? 16 : int'(blk.nbytes);
    if (n > 0) begin
      lo = blk.lo & byte_mask(n);
      hi = (n > 8) ? (blk.hi & byte_mask(n - 8)) : 64'd0;
      if (swap_q) begin
        lo = flip_bytes(lo);
        hi = flip_bytes(hi);
      end
      hash_state = churn(hash_state, lo, hi);
      msg_len = msg_len + 32'(n);
    end
    if (blk.last) begin
      len2 = {msg_len, msg_len};
      lo = hash_state[0];
      hi = hash_state[1];
      if (mix_len_q) begin
        lo ^= len2;
        hi ^= len2;
      end
      fin = {hash_state[3], hash_state[2], sbh_pkg::RND1, sbh_pkg::RND0};
      fin = churn(fin, lo, hi);
      if (swap_q) begin
        for (int i = 0; i < 4; i++) fin[i] = flip_bytes(fin[i]);
      end
      digests.push_back(fin);
      rearm_state();
    end
  endtask

  // Drive one beat, hold it until taken, then predict
  task automatic send_block(input block_t blk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_block_lo    <= blk.lo;
    in_block_hi    <= blk.hi;
    in_valid_bytes <= blk.nbytes;
    in_last_block  <= blk.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(blk);
  endtask

  // Drop valid, wait for every digest, then let any block in flight finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SEED: begin
        seed_q = value;
        rearm_state();
      end
      REG_MIX_LENGTH: mix_len_q = value[0];
      REG_BYTE_SWAP:  swap_q = value[0];
      default: ;
    endcase
  endtask

  // Write every register back to back; upper bits of the mode words are junk
  task automatic write_regs(input logic [63:0] seed, input logic ml, input logic bs,
                            input bit poke_unused);
    cfg_beat(REG_MIX_LENGTH, {63'(rand64()), ml});
    cfg_beat(REG_BYTE_SWAP, {63'(rand64()), bs});
    if (poke_unused) cfg_beat(REG_UNUSED, rand64());
    cfg_beat(REG_SEED, seed);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_block('{64'd0, 64'd0, 5'd0, 1'b1});
    send_block('{'1, '1, 5'd1, 1'b1});
    send_block('{'1, '1, 5'd16, 1'b1});
    send_block('{64'd0, 64'd0, 5'd16, 1'b1});
    send_block('{'1, '1, 5'd8, 1'b1});
    send_block('{'1, '1, 5'd9, 1'b1});
    send_block('{rand64(), rand64(), 5'd17, 1'b1});
    send_block('{'1, '1, 5'd31, 1'b1});
    // empty beat mid-message is ignored; a short beat mid-message is padded
    send_block('{rand64(), rand64(), 5'd0, 1'b0});
    send_block('{rand64(), rand64(), 5'd16, 1'b0});
    send_block('{'1, '1, 5'd5, 1'b0});
    send_block('{rand64(), rand64(), 5'd16, 1'b1});
  endtask

  task automatic test_mode_settings();
    wait_idle();
    write_regs('1, 1'b1, 1'b1, 1'b1);
    send_block('{64'd0, 64'd0, 5'd0, 1'b1});
    send_block('{'1, '1, 5'd16, 1'b1});
    send_block('{rand64(), rand64(), 5'd16, 1'b0});
    send_block('{rand64(), rand64(), 5'd3, 1'b1});
    wait_idle();
    write_regs(64'd0, 1'b1, 1'b0, 1'b0);
    send_block('{64'd0, 64'd0, 5'd0, 1'b1});
    send_block('{rand64(), rand64(), 5'd12, 1'b1});
    wait_idle();
    write_regs(rand64(), 1'b0, 1'b1, 1'b0);
    send_block('{rand64(), rand64(), 5'd7, 1'b1});
  endtask

  // A seed write drops the message in progress
  task automatic test_seed_abandons_message();
    wait_idle();
    send_block('{rand64(), rand64(), 5'd16, 1'b0});
    wait_idle();
    write_regs(rand64(), 1'b1, 1'b0, 1'b0);
    send_block('{rand64(), rand64(), 5'd16, 1'b1});
    send_block('{64'd0, 64'd0, 5'd0, 1'b1});
  endtask

  // Mostly well-formed messages; one in ten is noise with any byte count
  task automatic test_random_phase(input int idle_pct, input int stall_rate,
                                   input logic [63:0] seed, input logic ml,
                                   input logic bs, input bit poke_unused);
    int     sent;
    int     nblocks;
    bit     noisy;
    block_t blk;
    sent = 0;
    wait_idle();
    send_idle = idle_pct;
    stall_pct = stall_rate;
    write_regs(seed, ml, bs, poke_unused);
    while (sent < PHASE_BLOCKS) begin
      nblocks = ($urandom_range(7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      noisy = ($urandom_range(9) == 0);
      for (int b = 0; b < nblocks; b++) begin
        blk.lo = rand64();
        blk.hi = rand64();
        blk.last = (b == nblocks - 1);
        if (noisy) blk.nbytes = 5'($urandom_range(0, 31));
        else if (blk.last) blk.nbytes = 5'($urandom_range(1, 16));
        else blk.nbytes = 5'd16;
        send_block(blk);
        if (blk.nbytes != 5'd0 || blk.last) sent++;
      end
    end
  endtask

  // Stall the digest channel and check each digest beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        got_digest = {out_hash_word3, out_hash_word2, out_hash_word1, out_hash_word0};
        if (digests.size() == 0) begin
          $error("unexpected digest beat %h", got_digest);
          errors++;
        end else begin
          want_digest = digests.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got_digest[i] !== want_digest[i]) begin
              $error("hash_word%0d: expected %h, got %h", i, want_digest[i], got_digest[i]);
              errors++;
            end
          end
        end
      end
    end
  end

  // End the run if no channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[sse_style_256bit_block_hash] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    seed_q = '0;
    mix_len_q = 1'b0;
    swap_q = 1'b0;
    rearm_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_mode_settings();
    test_seed_abandons_message();
    test_random_phase(0, 0, 64'd0, 1'b0, 1'b0, 1'b0);
    test_random_phase(62, 0, '1, 1'b1, 1'b1, 1'b0);
    test_random_phase(0, 62, rand64(), 1'b1, 1'b0, 1'b0);
    test_random_phase(36, 36, rand64(), 1'($urandom), 1'($urandom), 1'b1);
    wait_idle();
    if (errors == 0) begin
      $display("[sse_style_256bit_block_hash] OK");
    end else begin
      $display("[sse_style_256bit_block_hash] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sbh_pkg.sv
rtl/sbh_alu.sv
rtl/sbh_mul.sv
rtl/sse_style_256bit_block_hash.sv
verif/testbench.sv
